@@ rtl/core/sgb_pkg.sv @@
// shared types and constants of the surrogate gradient backward block
package sgb_pkg;

  // field widths
  localparam int unsigned VOLT_W  = 16;
  localparam int unsigned GRAD_W  = 16;
  localparam int unsigned BETA_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned XQ_W    = 32;
  localparam int unsigned DER_W   = 24;

  // divider geometry
  localparam int unsigned NUM1_W  = 56;
  localparam int unsigned Q1_W    = 40;
  localparam int unsigned DEN1_W  = 65;
  localparam int unsigned Q2_W    = 24;
  localparam int unsigned DEN2_W  = 33;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // fixed-point constants
  localparam logic [16:0]       ONE_Q16      = 17'h10000;
  localparam logic [16:0]       LOG2E_Q16    = 17'd94548;
  localparam logic [BETA_W-1:0] BETA_DEFAULT = 16'd2560;

  // surrogate derivative selection
  typedef enum logic [MODE_W-1:0] {
    MODE_SIGMOID      = 3'd0,
    MODE_FAST_SIGMOID = 3'd1,
    MODE_ARCTAN       = 3'd2,
    MODE_SUPERSPIKE   = 3'd3,
    MODE_TRIANGULAR   = 3'd4,
    MODE_RECTANGULAR  = 3'd5
  } mode_e;

  // classified neuron handed from front to back
  typedef struct packed {
    logic [XQ_W-1:0]   xq;
    logic [BETA_W-1:0] beta;
    mode_e             mode;
    logic [GRAD_W-1:0] gmag;
    logic              gneg;
    logic              last;
  } item_t;

  // data riding along the back pipeline
  typedef struct packed {
    logic [BETA_W-1:0] beta;
    mode_e             mode;
    logic [GRAD_W-1:0] gmag;
    logic              gneg;
    logic              last;
    logic [DER_W-1:0]  ds;
  } side_t;

endpackage

@@ rtl/core/sgb_front.sv @@
// front part: distance to threshold, scaled distance and gradient sign split
module sgb_front
  import sgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic signed [VOLT_W-1:0] membrane_voltage_i,
  input  logic signed [GRAD_W-1:0] incoming_grad_i,
  input  logic                     last_in_i,
  input  logic [MODE_W-1:0]        mode_i,
  input  logic [BETA_W-1:0]        steepness_i,
  output item_t                    item_o
);

  localparam int unsigned DMAG_W = (FRAC_BITS < 15) ? 16 : FRAC_BITS + 2;
  localparam int unsigned DIFF_W = DMAG_W + 1;
  localparam int unsigned PROD_W = BETA_W + DMAG_W;
  localparam logic [DIFF_W-1:0] ONE_V = DIFF_W'(1) << FRAC_BITS;

  logic signed [DIFF_W-1:0] v_ext;
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;
  logic [DMAG_W-1:0]        dmag;
  logic [BETA_W-1:0]        beta;
  logic [PROD_W-1:0]        x_full;

  // distance from the threshold
  assign v_ext    = DIFF_W'(membrane_voltage_i);
  assign diff     = v_ext - $signed(ONE_V);
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign dmag     = diff_abs[DMAG_W-1:0];

  // zero steepness selects the default slope
  assign beta   = (steepness_i == '0) ? BETA_DEFAULT : steepness_i;
  assign x_full = beta * dmag;

  // scaled distance in q16 and gradient magnitude
  always_comb begin
    item_o.xq   = XQ_W'(x_full >> (FRAC_BITS - 8));
    item_o.beta = beta;
    item_o.mode = mode_e'(mode_i);
    item_o.gmag = incoming_grad_i[GRAD_W-1] ? (~incoming_grad_i + GRAD_W'(1))
                                            : incoming_grad_i;
    item_o.gneg = incoming_grad_i[GRAD_W-1];
    item_o.last = last_in_i;
  end

endmodule

@@ rtl/core/sgb_queue.sv @@
// short queue that decouples the front from the back pipeline
module sgb_queue
  import sgb_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t head_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ rtl/core/sgb_back.sv @@
// back part: derivative evaluation through two pipelined dividers, product and clip
module sgb_back
  import sgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  item_t             head_i,
  input  logic              head_valid_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [GRAD_W-1:0] outgoing_grad_o,
  output logic              last_out_o
);

  localparam int unsigned M_W = 24;
  localparam logic [M_W-1:0] CLIP = M_W'(5) << FRAC_BITS;

  logic en;

  // prep stage 1 registers
  logic                p1_valid_q;
  item_t               p1_item_q;
  logic [2*XQ_W-1:0]   p1_sq_q;
  logic [32:0]         p1_t_q;
  logic [2*XQ_W-1:0]   sq_d;
  logic [XQ_W+16:0]    tl_d;

  // divider pipelines
  logic                d1_valid_q [Q1_W+1];
  logic [DEN1_W-1:0]   d1_rem_q   [Q1_W+1];
  logic [Q1_W-1:0]     d1_acc_q   [Q1_W+1];
  logic [DEN1_W-1:0]   d1_den_q   [Q1_W+1];
  logic [DEN2_W-1:0]   d1_den2_q  [Q1_W+1];
  side_t               d1_side_q  [Q1_W+1];
  logic                d2_valid_q [Q2_W+1];
  logic [DEN2_W-1:0]   d2_rem_q   [Q2_W+1];
  logic [Q2_W-1:0]     d2_acc_q   [Q2_W+1];
  logic [DEN2_W-1:0]   d2_den_q   [Q2_W+1];
  side_t               d2_side_q  [Q2_W+1];

  // prep stage 2 signals
  logic [16:0]         e_val;
  logic [DEN2_W-1:0]   q_den;
  logic [17:0]         e_den;
  logic [32:0]         tri_p;
  logic [NUM1_W-1:0]   num1;
  logic [DEN1_W-1:0]   den1;
  logic [DEN2_W-1:0]   den2;
  side_t               side_p2;

  // tail registers
  logic                m1_valid_q;
  logic [39:0]         m1_prod_q;
  logic [Q2_W-1:0]     m1_q2_q;
  side_t               m1_side_q;
  logic                m2_valid_q;
  logic [M_W-1:0]      m2_mag_q;
  logic                m2_gneg_q;
  logic                m2_last_q;
  logic [DER_W-1:0]    der;
  logic [39:0]         gprod;
  logic [M_W-1:0]      mclip;
  logic [M_W-1:0]      mres;
  logic                out_valid_q;
  logic [GRAD_W-1:0]   out_grad_q;
  logic                out_last_q;

  // whole back pipeline moves unless a result waits on the output
  assign en    = !out_valid_q || !out_stall_i;
  assign pop_o = en && head_valid_i;

  // squares and exp argument
  assign sq_d = head_i.xq * head_i.xq;
  assign tl_d = head_i.xq * LOG2E_Q16;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
    end else if (en) begin
      p1_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_item_q <= head_i;
      p1_sq_q   <= sq_d;
      p1_t_q    <= tl_d[XQ_W+16:16];
    end
  end

  // piecewise exp(-x): halve the fraction, shift by the integer part
  assign e_val = (|p1_t_q[32:21]) ? 17'd0
               : (ONE_Q16 - {2'b00, p1_t_q[15:1]}) >> p1_t_q[20:16];
  assign q_den = DEN2_W'(ONE_Q16) + DEN2_W'(p1_item_q.xq);
  assign e_den = 18'(ONE_Q16) + 18'(e_val);
  assign tri_p = p1_item_q.beta * (ONE_Q16 - {1'b0, p1_item_q.xq[15:0]});

  // numerator and denominators per mode
  always_comb begin
    num1 = '0;
    den1 = DEN1_W'(1);
    den2 = DEN2_W'(1);
    side_p2.beta = p1_item_q.beta;
    side_p2.mode = p1_item_q.mode;
    side_p2.gmag = p1_item_q.gmag;
    side_p2.gneg = p1_item_q.gneg;
    side_p2.last = p1_item_q.last;
    side_p2.ds   = '0;
    case (p1_item_q.mode)
      MODE_SIGMOID: begin
        num1 = NUM1_W'({e_val, 32'd0});
        den1 = DEN1_W'(e_den);
        den2 = DEN2_W'(e_den);
      end
      MODE_FAST_SIGMOID: begin
        num1 = NUM1_W'({p1_item_q.beta, 39'd0});
        den1 = DEN1_W'(q_den);
        den2 = q_den;
      end
      MODE_ARCTAN: begin
        num1 = NUM1_W'({p1_item_q.beta, 40'd0});
        den1 = (DEN1_W'(1) << 32) + DEN1_W'(p1_sq_q);
      end
      MODE_SUPERSPIKE: begin
        num1 = NUM1_W'(1) << 48;
        den1 = DEN1_W'(q_den);
        den2 = q_den;
      end
      MODE_TRIANGULAR: begin
        side_p2.ds = (p1_item_q.xq[XQ_W-1:16] == '0) ? tri_p[31:8] : '0;
      end
      MODE_RECTANGULAR: begin
        side_p2.ds = (p1_item_q.xq[XQ_W-1:15] == '0) ? {p1_item_q.beta, 8'd0} : '0;
      end
      default: begin
        num1 = '0;
      end
    endcase
  end

  // first divider entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q[0] <= 1'b0;
    end else if (en) begin
      d1_valid_q[0] <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_rem_q[0]  <= DEN1_W'(num1 >> Q1_W);
      d1_acc_q[0]  <= num1[Q1_W-1:0];
      d1_den_q[0]  <= den1;
      d1_den2_q[0] <= den2;
      d1_side_q[0] <= side_p2;
    end
  end

  // first divider: one quotient bit per stage
  for (genvar k = 0; k < Q1_W; k++) begin : g_div1
    logic [DEN1_W:0] trial;
    logic [DEN1_W:0] diff;
    logic            take;

    assign trial = {d1_rem_q[k], d1_acc_q[k][Q1_W-1]};
    assign take  = trial >= {1'b0, d1_den_q[k]};
    assign diff  = trial - {1'b0, d1_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_valid_q[k+1] <= 1'b0;
      end else if (en) begin
        d1_valid_q[k+1] <= d1_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d1_rem_q[k+1]  <= take ? diff[DEN1_W-1:0] : trial[DEN1_W-1:0];
        d1_acc_q[k+1]  <= {d1_acc_q[k][Q1_W-2:0], take};
        d1_den_q[k+1]  <= d1_den_q[k];
        d1_den2_q[k+1] <= d1_den2_q[k];
        d1_side_q[k+1] <= d1_side_q[k];
      end
    end
  end

  // second divider entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d2_valid_q[0] <= 1'b0;
    end else if (en) begin
      d2_valid_q[0] <= d1_valid_q[Q1_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_rem_q[0]  <= DEN2_W'(d1_acc_q[Q1_W] >> Q2_W);
      d2_acc_q[0]  <= d1_acc_q[Q1_W][Q2_W-1:0];
      d2_den_q[0]  <= d1_den2_q[Q1_W];
      d2_side_q[0] <= d1_side_q[Q1_W];
    end
  end

  // second divider
  for (genvar k = 0; k < Q2_W; k++) begin : g_div2
    logic [DEN2_W:0] trial;
    logic [DEN2_W:0] diff;
    logic            take;

    assign trial = {d2_rem_q[k], d2_acc_q[k][Q2_W-1]};
    assign take  = trial >= {1'b0, d2_den_q[k]};
    assign diff  = trial - {1'b0, d2_den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_valid_q[k+1] <= 1'b0;
      end else if (en) begin
        d2_valid_q[k+1] <= d2_valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        d2_rem_q[k+1]  <= take ? diff[DEN2_W-1:0] : trial[DEN2_W-1:0];
        d2_acc_q[k+1]  <= {d2_acc_q[k][Q2_W-2:0], take};
        d2_den_q[k+1]  <= d2_den_q[k];
        d2_side_q[k+1] <= d2_side_q[k];
      end
    end
  end

  // sigmoid slope scaling
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_valid_q <= 1'b0;
    end else if (en) begin
      m1_valid_q <= d2_valid_q[Q2_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m1_prod_q <= d2_side_q[Q2_W].beta * d2_acc_q[Q2_W];
      m1_q2_q   <= d2_acc_q[Q2_W];
      m1_side_q <= d2_side_q[Q2_W];
    end
  end

  // derivative select
  always_comb begin
    case (m1_side_q.mode)
      MODE_SIGMOID:      der = m1_prod_q[31:8];
      MODE_FAST_SIGMOID: der = m1_q2_q;
      MODE_ARCTAN:       der = m1_q2_q;
      MODE_SUPERSPIKE:   der = m1_q2_q;
      MODE_TRIANGULAR:   der = m1_side_q.ds;
      MODE_RECTANGULAR:  der = m1_side_q.ds;
      default:           der = '0;
    endcase
  end

  // gradient product with round half away from zero
  assign gprod = m1_side_q.gmag * der + 40'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_valid_q <= 1'b0;
    end else if (en) begin
      m2_valid_q <= m1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m2_mag_q  <= gprod[39:16];
      m2_gneg_q <= m1_side_q.gneg;
      m2_last_q <= m1_side_q.last;
    end
  end

  // clip and restore sign
  assign mclip = (m2_mag_q > CLIP) ? CLIP : m2_mag_q;
  assign mres  = m2_gneg_q ? (~mclip + M_W'(1)) : mclip;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= m2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_grad_q <= mres[GRAD_W-1:0];
      out_last_q <= m2_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign outgoing_grad_o = out_grad_q;
  assign last_out_o      = out_last_q;

endmodule

@@ rtl/core/surrogate_gradient_backward.sv @@
// top level of the surrogate gradient backward block with its register port
// Usage: one neuron per input transaction (membrane voltage, incoming gradient,
// last flag), one output transaction per neuron (clipped outgoing gradient and
// the matching last flag), in order. Both channels move a transaction on a
// rising edge with valid high and stall low.
// The front accepts one neuron per cycle into a two-entry queue while the queue
// is not full; the back is a 70-stage pipeline (two radix-2 dividers of 40 and
// 24 stages plus prep, multiply and clip stages), and the sustained rate is one
// neuron per cycle while the receiver does not stall.
// When the receiver stalls a waiting result, the whole back pipeline holds; the
// front keeps taking neurons until the queue is full, then raises in_stall_o.
// Reset empties the queue and pipeline and sets mode to fast sigmoid and
// steepness to 10.0. Registers (APB): 0x0 surrogate_mode, 0x4 steepness;
// write them only while no neuron is in flight.
module surrogate_gradient_backward
  import sgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 12
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // neuron input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [VOLT_W-1:0] membrane_voltage_i,
  input  logic signed [GRAD_W-1:0] incoming_grad_i,
  input  logic                     last_in_i,
  // gradient output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [GRAD_W-1:0] outgoing_grad_o,
  output logic                     last_out_o,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic REG_MODE      = 1'b0;
  localparam logic REG_STEEPNESS = 1'b1;
  localparam int   CLIP_I        = 5 << FRAC_BITS;

  logic [MODE_W-1:0] mode_q;
  logic [BETA_W-1:0] steep_q;
  logic              reg_wr;
  logic              reg_idx;
  item_t             front_item;
  item_t             head_item;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic              in_take;
  logic [GRAD_W-1:0] grad_raw;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_W'(MODE_FAST_SIGMOID);
      steep_q <= BETA_DEFAULT;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_MODE:      mode_q  <= pwdata[MODE_W-1:0];
        REG_STEEPNESS: steep_q <= pwdata[BETA_W-1:0];
        default:       mode_q  <= mode_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:      prdata = 32'(mode_q);
      REG_STEEPNESS: prdata = 32'(steep_q);
      default:       prdata = '0;
    endcase
  end

  // front: classify the incoming neuron
  sgb_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .membrane_voltage_i(membrane_voltage_i),
    .incoming_grad_i   (incoming_grad_i),
    .last_in_i         (last_in_i),
    .mode_i            (mode_q),
    .steepness_i       (steep_q),
    .item_o            (front_item)
  );

  assign in_stall_o = q_full;
  assign in_take    = in_valid_i && !q_full;

  sgb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_take),
    .item_i (front_item),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .head_o (head_item)
  );

  // back: derivative, product and clip
  sgb_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_i         (head_item),
    .head_valid_i   (q_valid),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .outgoing_grad_o(grad_raw),
    .last_out_o     (last_out_o)
  );

  assign outgoing_grad_o = $signed(grad_raw);

  // a full queue cannot drain while the output is held
  a_queue_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i && in_stall_o) |=> in_stall_o)
    else $error("queue drained while back pipeline was stalled");

  // results stay inside the clip bound
  a_clip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((FRAC_BITS > 12) ||
                     (($signed(outgoing_grad_o) <= CLIP_I) &&
                      ($signed(outgoing_grad_o) >= -CLIP_I))))
    else $error("outgoing gradient outside clip bound");

  // mode register reads back only its own bits
  a_mode_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && !paddr[2]) |-> (prdata[31:MODE_W] == '0))
    else $error("mode register read returned stray bits");

endmodule

@@ sim/surrogate_gradient_backward_test.sv @@
// self-checking testbench of the surrogate gradient backward block
module surrogate_gradient_backward_test
  import sgb_pkg::*;
();

  localparam int unsigned FRAC = 12;
  localparam logic [2:0] ADDR_MODE = 3'd0;
  localparam logic [2:0] ADDR_STEEP = 3'd4;
  localparam int unsigned PIPE_LAT = 80;
  localparam longint unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0] MODE_OFF6 = 3'd6;
  localparam logic [2:0] MODE_OFF7 = 3'd7;

  // one neuron of stimulus, expected gradient given only where obvious
  typedef struct packed {
    logic [15:0] volt;
    logic [15:0] grad;
    logic        last;
    logic        has_exp;
    logic [15:0] exp_grad;
  } neuron_t;

  typedef struct packed {
    logic [15:0] grad;
    logic        last;
  } grad_out_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, last_in_i;
  logic signed [15:0] membrane_voltage_i, incoming_grad_i;
  logic out_valid_o, out_stall_i, last_out_o;
  logic signed [15:0] outgoing_grad_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  surrogate_gradient_backward #(.FRAC_BITS(FRAC)) dut (.*);

  // register shadow used by the predictor
  logic [2:0] mode_sh;
  logic [15:0] steep_sh;

  grad_out_t pending_grads[$];
  int unsigned mismatch_cnt = 0;
  bit quiet_phase;
  int unsigned hold_req;
  bit hold_done;
  longint unsigned cycle_cnt = 0;

  // clock and cycle limit
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic logic [63:0] exp_neg(input logic [63:0] xq);
    logic [63:0] t, n, f;
    t = (xq * 64'd94548) >> 16;
    n = t >> 16;
    f = t & 64'hFFFF;
    if (n >= 32) return 64'd0;
    return (64'd65536 - (f >> 1)) >> n;
  endfunction

  // surrogate derivative in unsigned Q16
  function automatic logic [63:0] derivative(input logic [2:0] mode, input logic [63:0] b,
                                             input logic [63:0] xq);
    logic [63:0] q, e, s;
    q = 64'd65536 + xq;
    case (mode)
      MODE_SIGMOID: begin
        e = exp_neg(xq);
        s = ((e << 32) / (64'd65536 + e)) / (64'd65536 + e);
        return (b * s) >> 8;
      end
      MODE_FAST_SIGMOID: return ((b << 39) / q) / q;
      MODE_ARCTAN: return (b << 40) / ((64'd1 << 32) + xq * xq);
      MODE_SUPERSPIKE: return ((64'd1 << 48) / q) / q;
      MODE_TRIANGULAR: return (xq < 64'd65536) ? ((b * (64'd65536 - xq)) >> 8) : 64'd0;
      MODE_RECTANGULAR: return (xq < 64'd32768) ? (b << 8) : 64'd0;
      default: return 64'd0;
    endcase
  endfunction

  // clipped outgoing gradient for one neuron
  function automatic logic [15:0] backprop_grad(input logic [15:0] volt, input logic [15:0] grad);
    longint d, g;
    logic [63:0] dmag, gmag, b, xq, dq, m, lim;
    d = longint'($signed(volt)) - (longint'(1) << FRAC);
    g = longint'($signed(grad));
    dmag = (d < 0) ? -d : d;
    gmag = (g < 0) ? -g : g;
    b = (steep_sh == 0) ? 64'd2560 : 64'(steep_sh);
    xq = (b * dmag) >> (FRAC - 8);
    dq = derivative(mode_sh, b, xq);
    m = (gmag * dq + 64'd32768) >> 16;
    lim = 64'd5 << FRAC;
    if (m > lim) m = lim;
    return (g < 0) ? 16'(-m) : 16'(m);
  endfunction

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MODE) mode_sh = data[2:0];
    else steep_sh = data[15:0];
  endtask

  // send one neuron, with optional idle burst before it
  task automatic send_neuron(input neuron_t nr, input bit allow_gap);
    grad_out_t eo;
    if (allow_gap && !quiet_phase && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    membrane_voltage_i <= nr.volt;
    incoming_grad_i <= nr.grad;
    last_in_i <= nr.last;
    eo.grad = nr.has_exp ? nr.exp_grad : backprop_grad(nr.volt, nr.grad);
    eo.last = nr.last;
    pending_grads.push_back(eo);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT) @(posedge clk_i);
  endtask

  function automatic neuron_t rand_neuron();
    neuron_t nr;
    nr.has_exp = 1'b0;
    nr.exp_grad = '0;
    nr.last = 1'($urandom_range(0, 1));
    nr.grad = 16'($urandom);
    // mostly voltages near threshold where derivatives are nonzero
    case ($urandom_range(0, 3))
      0: nr.volt = 16'($urandom);
      default: nr.volt = 16'(4096 + $signed($urandom_range(0, 2048)) - 1024);
    endcase
    return nr;
  endfunction

  // receiver: random stall bursts, plus one long hold when requested
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0 && !hold_done) begin
        out_stall_i <= 1'b1;
        repeat (hold_req) @(posedge clk_i);
        hold_done = 1'b1;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // compare every output transaction with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_grads.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10) $display("unexpected output grad %h", outgoing_grad_o);
      end else begin
        if (outgoing_grad_o !== pending_grads[0].grad || last_out_o !== pending_grads[0].last)
        begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("mismatch: exp grad %h last %b, got grad %h last %b",
                     pending_grads[0].grad, pending_grads[0].last,
                     outgoing_grad_o, last_out_o);
        end
        void'(pending_grads.pop_front());
      end
    end
  end

  neuron_t directed[] = '{
    '{16'h1000, 16'h7FFF, 1'b0, 1'b1, 16'h5000},
    '{16'h1000, 16'h8000, 1'b1, 1'b1, 16'hB000},
    '{16'h1000, 16'h0000, 1'b0, 1'b1, 16'h0000},
    '{16'h7FFF, 16'h7FFF, 1'b1, 1'b0, 16'h0000},
    '{16'h8000, 16'h8000, 1'b0, 1'b0, 16'h0000},
    '{16'h1100, 16'h1000, 1'b1, 1'b0, 16'h0000},
    '{16'h0F00, 16'hF000, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 16'h0001, 1'b1, 1'b0, 16'h0000}
  };

  initial begin
    neuron_t nr;
    logic [2:0] modes[8];
    logic [15:0] steeps[6];
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    membrane_voltage_i = '0;
    incoming_grad_i = '0;
    last_in_i = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_phase = 1'b0;
    hold_req = 0;
    mode_sh = MODE_FAST_SIGMOID;
    steep_sh = 16'd2560;
    modes = '{MODE_SIGMOID, MODE_FAST_SIGMOID, MODE_ARCTAN, MODE_SUPERSPIKE,
              MODE_TRIANGULAR, MODE_RECTANGULAR, MODE_OFF6, MODE_OFF7};
    steeps = '{16'd0, 16'd2560, 16'd1, 16'hFFFF, 16'd256, 16'd20000};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: fast sigmoid, beta 10; at threshold D is beta/2
    foreach (directed[i]) send_neuron(directed[i], 1'b0);
    drain_all();

    // every mode under the same three directed neurons, with zero and extreme steepness
    foreach (modes[m]) begin
      reg_write(ADDR_MODE, {29'd0, modes[m]});
      reg_write(ADDR_STEEP, {16'd0, steeps[m % 6]});
      for (int k = 0; k < 3; k++) begin
        nr = directed[3 + k];
        nr.has_exp = (modes[m] == MODE_OFF6 || modes[m] == MODE_OFF7);
        nr.exp_grad = 16'h0000;
        send_neuron(nr, 1'b1);
      end
      drain_all();
    end

    // random phases over mode and steepness settings
    for (int ph = 0; ph < 16; ph++) begin
      reg_write(ADDR_MODE, {29'd0, 3'($urandom_range(0, 7))});
      reg_write(ADDR_STEEP, {16'd0, (ph % 4 == 0) ? steeps[ph % 6] : 16'($urandom)});
      if (ph == 3) hold_req = 300;
      if (ph >= 14) quiet_phase = 1'b1;
      for (int k = 0; k < 56; k++) send_neuron(rand_neuron(), 1'b1);
      drain_all();
    end

    if (mismatch_cnt == 0 && pending_grads.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
